@@ rtl/usbcre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbcre_pkg - shared types and codes for the endpoint-zero request engine
// Request kinds, standard request codes, descriptor types, packet sources,
// configuration register indexes, reset values and device state codes.
// ----------------------------------------------------------------------------
package usbcre_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_SETUP = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    // bmRequestType fields
    localparam logic [7:0] RT_TYPE_MASK  = 8'h60;
    localparam logic [4:0] RCPT_DEVICE   = 5'd0;
    localparam logic [4:0] RCPT_IFACE    = 5'd1;
    localparam logic [4:0] RCPT_ENDPOINT = 5'd2;

    // Standard request codes
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;

    // Descriptor types
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_HID    = 8'h21;
    localparam logic [7:0] DT_REPORT = 8'h22;

    // Packet sources
    localparam logic [2:0] SRC_ZLP    = 3'd0;
    localparam logic [2:0] SRC_DEVICE = 3'd1;
    localparam logic [2:0] SRC_CONFIG = 3'd2;
    localparam logic [2:0] SRC_HID    = 3'd3;
    localparam logic [2:0] SRC_REPORT = 3'd4;
    localparam logic [2:0] SRC_STATUS = 3'd5;

    localparam logic [7:0] STATUS_WAKEUP = 8'h02;
    localparam logic [6:0] STATUS_BYTES  = 7'd2;

    localparam int         ADDRESS_BITS = 7;
    localparam int         MAX_PACKET   = 64;
    localparam logic [6:0] MIN_PACKET   = 7'd8;

    // Configuration register indexes
    localparam int         CFG_IDX_BITS = 3;
    localparam logic [2:0] CFG_MAX_PACKET   = 3'd0;
    localparam logic [2:0] CFG_HID_IFACE    = 3'd1;
    localparam logic [2:0] CFG_DEVICE_LEN   = 3'd2;
    localparam logic [2:0] CFG_CONFIG_LEN   = 3'd3;
    localparam logic [2:0] CFG_HID_OFFSET   = 3'd4;
    localparam logic [2:0] CFG_HID_LEN      = 3'd5;
    localparam logic [2:0] CFG_REPORT_LEN   = 3'd6;

    // Configuration reset values
    localparam logic [6:0] RST_MAX_PACKET = 7'd64;
    localparam logic [7:0] RST_HID_IFACE  = 8'd1;
    localparam logic [7:0] RST_DEVICE_LEN = 8'd18;
    localparam logic [7:0] RST_CONFIG_LEN = 8'd34;
    localparam logic [7:0] RST_HID_OFFSET = 8'd18;
    localparam logic [7:0] RST_HID_LEN    = 8'd9;
    localparam logic [7:0] RST_REPORT_LEN = 8'd63;

    // Device state machine
    typedef enum logic [3:0] {
        ST_POWERED    = 4'b0001,
        ST_DEFAULT    = 4'b0010,
        ST_ADDRESSED  = 4'b0100,
        ST_CONFIGURED = 4'b1000
    } t_dev_state;

    localparam logic [1:0] DSTATE_POWERED    = 2'd0;
    localparam logic [1:0] DSTATE_DEFAULT    = 2'd1;
    localparam logic [1:0] DSTATE_ADDRESSED  = 2'd2;
    localparam logic [1:0] DSTATE_CONFIGURED = 2'd3;

    function automatic logic [1:0] encode_state(t_dev_state s);
        logic [1:0] code;
        case (s)
            ST_POWERED:    code = DSTATE_POWERED;
            ST_DEFAULT:    code = DSTATE_DEFAULT;
            ST_ADDRESSED:  code = DSTATE_ADDRESSED;
            ST_CONFIGURED: code = DSTATE_CONFIGURED;
            default:       code = DSTATE_POWERED;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/usb_control_request_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_request_engine_core - endpoint-zero standard request engine
// Decodes setup packets, IN transmit-done events and bus resets for a HID
// keyboard and emits one packet descriptor (source, offset, count) per item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     tdata / tuser
//  s_axis    in   s_axis_tvalid/s_axis_tready   64b setup fields / 2b kind
//  m_axis    out  m_axis_tvalid/m_axis_tready   40b packet + status / 2b flags
//  cfg       in   i_cfg_we (no wait)            i_cfg_addr 3b, i_cfg_data 8b
//
//  Each item passes through the input register, where decode and the state
//  update happen, and then the result register. One item is accepted per
//  cycle while the result register is not stalled. A stalled result holds
//  in the output register while the input register may still take one item.
//  Reset (i_rst_n low, synchronous) empties both stages, returns the device
//  to powered and loads register defaults.
// ----------------------------------------------------------------------------
module usb_control_request_engine_core #(
    parameter int MAX_PACKET = usbcre_pkg::MAX_PACKET
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [usbcre_pkg::CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [7:0]                         i_cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] request_type, [15:8] request_code, [31:16] setup_value,
    // [47:32] setup_index, [63:48] setup_length
    input  logic [63:0]                        s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                         s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] packet_source, [10:3] packet_offset, [17:11] packet_count,
    // [25:18] status_low_byte, [32:26] device_address, [34:33] device_state,
    // [35] wakeup_enabled, [39:36] zero
    output logic [39:0]                        m_axis_tdata,
    // [0] stall_res, [1] send_packet
    output logic [1:0]                         m_axis_tuser
);
    import usbcre_pkg::*;

    localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);
    localparam int         AB     = ADDRESS_BITS;

    // ---------------- configuration registers ----------------
    logic [6:0] r_cfg_mps;
    logic [7:0] r_cfg_hid_iface, r_cfg_dev_len, r_cfg_cfg_len;
    logic [7:0] r_cfg_hid_off, r_cfg_hid_len, r_cfg_rep_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mps       <= RST_MAX_PACKET;
            r_cfg_hid_iface <= RST_HID_IFACE;
            r_cfg_dev_len   <= RST_DEVICE_LEN;
            r_cfg_cfg_len   <= RST_CONFIG_LEN;
            r_cfg_hid_off   <= RST_HID_OFFSET;
            r_cfg_hid_len   <= RST_HID_LEN;
            r_cfg_rep_len   <= RST_REPORT_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_PACKET: r_cfg_mps       <= i_cfg_data[6:0];
                CFG_HID_IFACE:  r_cfg_hid_iface <= i_cfg_data;
                CFG_DEVICE_LEN: r_cfg_dev_len   <= i_cfg_data;
                CFG_CONFIG_LEN: r_cfg_cfg_len   <= i_cfg_data;
                CFG_HID_OFFSET: r_cfg_hid_off   <= i_cfg_data;
                CFG_HID_LEN:    r_cfg_hid_len   <= i_cfg_data;
                CFG_REPORT_LEN: r_cfg_rep_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_in_valid, r_out_valid;
    logic out_free, advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;

    // input register: hold the item while the result register is blocked
    logic [1:0]  r_in_kind;
    logic [7:0]  r_in_rtype, r_in_code;
    logic [15:0] r_in_value, r_in_index, r_in_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind   <= s_axis_tuser;
            r_in_rtype  <= s_axis_tdata[7:0];
            r_in_code   <= s_axis_tdata[15:8];
            r_in_value  <= s_axis_tdata[31:16];
            r_in_index  <= s_axis_tdata[47:32];
            r_in_length <= s_axis_tdata[63:48];
        end
    end

    // ---------------- engine state ----------------
    t_dev_state    r_state;
    logic [AB-1:0] r_addr, r_pend_addr;
    logic          r_pend_valid, r_wakeup;
    logic          r_xfer_active;
    logic [2:0]    r_xfer_src;
    logic [7:0]    r_xfer_off, r_xfer_rem;

    // Clamp the packet size into the legal range.
    logic [6:0] mps;
    always_comb begin
        if (r_cfg_mps < MIN_PACKET) begin
            mps = MIN_PACKET;
        end else if (r_cfg_mps > MaxPkt) begin
            mps = MaxPkt;
        end else begin
            mps = r_cfg_mps;
        end
    end

    // ---------------- request decode ----------------
    logic [7:0] dtype, didx;
    logic       setup_ok;
    logic       do_start, do_status, do_zlp, do_pend, do_wake_set, do_wake_clr;
    logic [2:0] st_src;
    logic [7:0] st_base, st_len;
    logic [7:0] status_byte;

    assign dtype = r_in_value[15:8];
    assign didx  = r_in_value[7:0];

    always_comb begin
        setup_ok    = 1'b0;
        do_start    = 1'b0;
        do_status   = 1'b0;
        do_zlp      = 1'b0;
        do_pend     = 1'b0;
        do_wake_set = 1'b0;
        do_wake_clr = 1'b0;
        st_src      = SRC_ZLP;
        st_base     = 8'd0;
        st_len      = 8'd0;
        status_byte = 8'd0;
        // decode setup items only; other kinds carry a don't-care payload
        if (r_in_kind == KIND_SETUP && (r_in_rtype & RT_TYPE_MASK) == 8'd0) begin
            case (r_in_rtype[4:0])
                RCPT_DEVICE: begin
                    case (r_in_code)
                        REQ_GET_STATUS: begin
                            setup_ok    = 1'b1;
                            do_status   = 1'b1;
                            status_byte = r_wakeup ? STATUS_WAKEUP : 8'd0;
                        end
                        REQ_CLEAR_FEATURE: begin
                            if (r_in_value == FEAT_REMOTE_WAKEUP) begin
                                setup_ok    = 1'b1;
                                do_zlp      = 1'b1;
                                do_wake_clr = 1'b1;
                            end
                        end
                        REQ_SET_FEATURE: begin
                            if (r_in_value == FEAT_REMOTE_WAKEUP) begin
                                setup_ok    = 1'b1;
                                do_zlp      = 1'b1;
                                do_wake_set = 1'b1;
                            end
                        end
                        REQ_SET_ADDRESS: begin
                            setup_ok = 1'b1;
                            do_zlp   = 1'b1;
                            do_pend  = 1'b1;
                        end
                        REQ_GET_DESCRIPTOR: begin
                            if (dtype == DT_DEVICE) begin
                                setup_ok = 1'b1;
                                do_start = 1'b1;
                                st_src   = SRC_DEVICE;
                                st_len   = r_cfg_dev_len;
                            end else if (dtype == DT_CONFIG && didx == 8'd0) begin
                                setup_ok = 1'b1;
                                do_start = 1'b1;
                                st_src   = SRC_CONFIG;
                                st_len   = r_cfg_cfg_len;
                            end
                        end
                        default: ;
                    endcase
                end
                RCPT_IFACE: begin
                    // only descriptor requests aimed at the HID interface
                    if (r_in_code == REQ_GET_DESCRIPTOR &&
                        r_in_index == {8'd0, r_cfg_hid_iface} && didx == 8'd0) begin
                        if (dtype == DT_HID) begin
                            setup_ok = 1'b1;
                            do_start = 1'b1;
                            st_src   = SRC_HID;
                            st_base  = r_cfg_hid_off;
                            st_len   = r_cfg_hid_len;
                        end else if (dtype == DT_REPORT) begin
                            setup_ok = 1'b1;
                            do_start = 1'b1;
                            st_src   = SRC_REPORT;
                            st_len   = r_cfg_rep_len;
                        end
                    end
                end
                RCPT_ENDPOINT: begin
                    if (r_in_code == REQ_GET_STATUS && r_in_index == 16'd0) begin
                        setup_ok  = 1'b1;
                        do_status = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- chunk of a descriptor transfer ----------------
    // A new transfer clamps its length to wLength; a running one continues
    // from the stored offset and remainder.
    logic [7:0] c_rem, c_off, start_size;
    logic [2:0] c_src;
    logic [6:0] chunk;
    logic       chunk_full;

    assign start_size = ({8'd0, st_len} > r_in_length) ? r_in_length[7:0] : st_len;
    assign c_rem      = do_start ? start_size : r_xfer_rem;
    assign c_off      = do_start ? st_base    : r_xfer_off;
    assign c_src      = do_start ? st_src     : r_xfer_src;
    assign chunk_full = c_rem >= {1'b0, mps};
    assign chunk      = chunk_full ? mps : c_rem[6:0];

    // ---------------- next state and result ----------------
    t_dev_state    n_state;
    logic [AB-1:0] n_addr, n_pend_addr;
    logic          n_pend_valid, n_wakeup, n_xfer_active;
    logic [2:0]    n_xfer_src;
    logic [7:0]    n_xfer_off, n_xfer_rem;
    logic          res_stall, res_send, emit_chunk;
    logic [2:0]    res_src;
    logic [7:0]    res_off, res_status;
    logic [6:0]    res_cnt;

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_pend_addr   = r_pend_addr;
        n_pend_valid  = r_pend_valid;
        n_wakeup      = r_wakeup;
        n_xfer_active = r_xfer_active;
        n_xfer_src    = r_xfer_src;
        n_xfer_off    = r_xfer_off;
        n_xfer_rem    = r_xfer_rem;
        res_stall     = 1'b0;
        res_send      = 1'b0;
        res_src       = SRC_ZLP;
        res_off       = 8'd0;
        res_cnt       = 7'd0;
        res_status    = 8'd0;
        emit_chunk    = 1'b0;
        case (r_in_kind)
            KIND_SETUP: begin
                // any setup ends a running transfer, stalled or not
                n_xfer_active = 1'b0;
                res_stall     = !setup_ok;
                emit_chunk    = do_start;
                if (do_wake_set) begin
                    n_wakeup = 1'b1;
                end
                if (do_wake_clr) begin
                    n_wakeup = 1'b0;
                end
                if (do_pend) begin
                    n_pend_addr  = r_in_value[AB-1:0];
                    n_pend_valid = 1'b1;
                end
                if (do_zlp) begin
                    res_send = 1'b1;
                end
                if (do_status) begin
                    res_send   = 1'b1;
                    res_src    = SRC_STATUS;
                    res_cnt    = STATUS_BYTES;
                    res_status = status_byte;
                end
            end
            KIND_DONE: begin
                if (r_xfer_active) begin
                    emit_chunk = 1'b1;
                end else if (r_pend_valid) begin
                    // status stage done: commit the new address
                    n_addr       = r_pend_addr;
                    n_state      = (r_pend_addr != '0) ? ST_ADDRESSED : ST_DEFAULT;
                    n_pend_valid = 1'b0;
                end
            end
            KIND_RESET: begin
                n_pend_valid  = 1'b0;
                n_wakeup      = 1'b0;
                n_xfer_active = 1'b0;
                n_addr        = '0;
                n_state       = ST_DEFAULT;
            end
            default: ;
        endcase
        if (emit_chunk) begin
            res_send      = 1'b1;
            res_cnt       = chunk;
            res_src       = (chunk == 7'd0) ? SRC_ZLP : c_src;
            res_off       = (chunk == 7'd0) ? 8'd0 : c_off;
            n_xfer_src    = c_src;
            n_xfer_off    = c_off + {1'b0, chunk};
            n_xfer_rem    = c_rem - {1'b0, chunk};
            n_xfer_active = chunk_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_POWERED;
            r_addr        <= '0;
            r_pend_addr   <= '0;
            r_pend_valid  <= 1'b0;
            r_wakeup      <= 1'b0;
            r_xfer_active <= 1'b0;
            r_xfer_src    <= SRC_ZLP;
            r_xfer_off    <= 8'd0;
            r_xfer_rem    <= 8'd0;
        end else if (advance) begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_pend_addr   <= n_pend_addr;
            r_pend_valid  <= n_pend_valid;
            r_wakeup      <= n_wakeup;
            r_xfer_active <= n_xfer_active;
            r_xfer_src    <= n_xfer_src;
            r_xfer_off    <= n_xfer_off;
            r_xfer_rem    <= n_xfer_rem;
        end
    end

    // ---------------- result register ----------------
    logic [39:0] r_out_data;
    logic [1:0]  r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_user <= {res_send, res_stall};
            r_out_data <= {4'd0, n_wakeup, encode_state(n_state), 7'(n_addr),
                           res_status, res_cnt, res_off, res_src};
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for usb_control_request_engine_core
// Drives setup packets, transmit-done events and bus resets into the engine
// and predicts every reply with a behavioral copy of the endpoint-zero logic.
// Directed tests cover each request and corner case. Three random phases
// follow, each under a different idling mix. Between phases the descriptor
// registers are reprogrammed.
// ----------------------------------------------------------------------------
module tb;
    import usbcre_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 4;
    localparam logic [7:0] DIR_IN        = 8'h80;
    localparam logic [7:0] RT_VENDOR     = 8'h40;

    typedef struct packed {
        logic       stall;
        logic       send;
        logic [2:0] src;
        logic [7:0] offset;
        logic [6:0] count;
        logic [7:0] status;
        logic [6:0] addr;
        logic [1:0] dstate;
        logic       wake;
    } t_ep0_reply;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_addr    = '0;
    logic [7:0]              i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [7:0] request_type, [15:8] request_code, [31:16] setup_value,
    // [47:32] setup_index, [63:48] setup_length
    logic [63:0]             s_axis_tdata  = '0;
    // [1:0] req_type
    logic [1:0]              s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [2:0] packet_source, [10:3] packet_offset, [17:11] packet_count,
    // [25:18] status_low_byte, [32:26] device_address, [34:33] device_state,
    // [35] wakeup_enabled, [39:36] zero
    logic [39:0]             m_axis_tdata;
    // [0] stall_res, [1] send_packet
    logic [1:0]              m_axis_tuser;

    // Mirror of the register file
    logic [6:0] mps_reg;
    logic [7:0] hid_iface_reg, dev_len_reg, cfg_len_reg;
    logic [7:0] hid_off_reg, hid_len_reg, rep_len_reg;

    // Mirror of the device and transfer state
    logic [1:0] dev_state;
    logic [6:0] cur_addr, pend_addr;
    logic       pend_valid, wake_on, xfer_on;
    logic [2:0] xfer_src;
    logic [7:0] xfer_off, xfer_left;

    t_ep0_reply reply_now;
    t_ep0_reply reply_head;
    t_ep0_reply replies_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;
    int served_items  = 0;

    usb_control_request_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Endpoint-zero behavior
    // ------------------------------------------------------------------
    function automatic void clear_endpoint_model();
        mps_reg       = RST_MAX_PACKET;
        hid_iface_reg = RST_HID_IFACE;
        dev_len_reg   = RST_DEVICE_LEN;
        cfg_len_reg   = RST_CONFIG_LEN;
        hid_off_reg   = RST_HID_OFFSET;
        hid_len_reg   = RST_HID_LEN;
        rep_len_reg   = RST_REPORT_LEN;
        dev_state     = DSTATE_POWERED;
        cur_addr      = '0;
        pend_addr     = '0;
        pend_valid    = 1'b0;
        wake_on       = 1'b0;
        xfer_on       = 1'b0;
        xfer_src      = SRC_ZLP;
        xfer_off      = '0;
        xfer_left     = '0;
    endfunction

    // Clamp the programmed packet size into the legal window
    function automatic logic [7:0] packet_limit();
        if (mps_reg < MIN_PACKET)
            return {1'b0, MIN_PACKET};
        if (mps_reg > MAX_PACKET)
            return 8'(MAX_PACKET);
        return {1'b0, mps_reg};
    endfunction

    function automatic void emit_fixed(logic [2:0] src, logic [6:0] count, logic [7:0] status);
        reply_now.send   = 1'b1;
        reply_now.src    = src;
        reply_now.offset = '0;
        reply_now.count  = count;
        reply_now.status = status;
    endfunction

    // Arm the next chunk; a short chunk (or an empty one) ends the transfer
    function automatic void emit_next_chunk();
        logic [7:0] lim;
        logic [7:0] n;
        lim = packet_limit();
        n   = (xfer_left > lim) ? lim : xfer_left;
        reply_now.send   = 1'b1;
        reply_now.count  = n[6:0];
        reply_now.status = '0;
        reply_now.src    = (n == 8'd0) ? SRC_ZLP : xfer_src;
        reply_now.offset = (n == 8'd0) ? 8'd0 : xfer_off;
        xfer_left = xfer_left - n;
        xfer_off  = xfer_off + n;
        xfer_on   = (n >= lim);
    endfunction

    function automatic void begin_transfer(logic [2:0] src, logic [7:0] base, logic [7:0] len,
                                           logic [15:0] wlen);
        xfer_src  = src;
        xfer_off  = base;
        xfer_left = ({8'd0, len} > wlen) ? wlen[7:0] : len;
        emit_next_chunk();
    endfunction

    function automatic logic serve_device(logic [7:0] code, logic [15:0] val, logic [15:0] len);
        logic ok;
        ok = 1'b1;
        case (code)
            REQ_GET_STATUS:
                emit_fixed(SRC_STATUS, STATUS_BYTES, wake_on ? STATUS_WAKEUP : 8'h00);
            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                if (val == FEAT_REMOTE_WAKEUP) begin
                    wake_on = (code == REQ_SET_FEATURE);
                    emit_fixed(SRC_ZLP, 7'd0, 8'h00);
                end else begin
                    ok = 1'b0;
                end
            end
            REQ_SET_ADDRESS: begin
                // keep the low address bits; the switch waits for the status stage
                pend_addr  = val[ADDRESS_BITS-1:0];
                pend_valid = 1'b1;
                emit_fixed(SRC_ZLP, 7'd0, 8'h00);
            end
            REQ_GET_DESCRIPTOR: begin
                if (val[15:8] == DT_DEVICE)
                    begin_transfer(SRC_DEVICE, 8'd0, dev_len_reg, len);
                else if (val[15:8] == DT_CONFIG && val[7:0] == 8'd0)
                    begin_transfer(SRC_CONFIG, 8'd0, cfg_len_reg, len);
                else
                    ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic serve_interface(logic [7:0] code, logic [15:0] val, logic [15:0] idx,
                                             logic [15:0] len);
        if (code != REQ_GET_DESCRIPTOR || idx != {8'd0, hid_iface_reg} || val[7:0] != 8'd0)
            return 1'b0;
        if (val[15:8] == DT_HID) begin
            begin_transfer(SRC_HID, hid_off_reg, hid_len_reg, len);
            return 1'b1;
        end
        if (val[15:8] == DT_REPORT) begin
            begin_transfer(SRC_REPORT, 8'd0, rep_len_reg, len);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic serve_setup(logic [63:0] setup);
        if ((setup[7:0] & RT_TYPE_MASK) != 8'h00)
            return 1'b0;
        case (setup[4:0])
            RCPT_DEVICE:
                return serve_device(setup[15:8], setup[31:16], setup[63:48]);
            RCPT_IFACE:
                return serve_interface(setup[15:8], setup[31:16], setup[47:32], setup[63:48]);
            RCPT_ENDPOINT: begin
                if (setup[15:8] != REQ_GET_STATUS || setup[47:32] != 16'd0)
                    return 1'b0;
                emit_fixed(SRC_STATUS, STATUS_BYTES, 8'h00);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Work out the reply to one item and advance the mirrored state
    function automatic t_ep0_reply endpoint_reply(logic [1:0] kind, logic [63:0] setup);
        reply_now = '0;
        case (kind)
            KIND_SETUP: begin
                // any setup aborts a running descriptor transfer
                xfer_on = 1'b0;
                reply_now.stall = !serve_setup(setup);
            end
            KIND_DONE: begin
                if (xfer_on) begin
                    emit_next_chunk();
                end else if (pend_valid) begin
                    cur_addr   = pend_addr;
                    dev_state  = (cur_addr != '0) ? DSTATE_ADDRESSED : DSTATE_DEFAULT;
                    pend_valid = 1'b0;
                end
            end
            KIND_RESET: begin
                pend_valid = 1'b0;
                wake_on    = 1'b0;
                xfer_on    = 1'b0;
                cur_addr   = '0;
                dev_state  = DSTATE_DEFAULT;
            end
            default: ;
        endcase
        reply_now.addr   = cur_addr;
        reply_now.dstate = dev_state;
        reply_now.wake   = wake_on;
        return reply_now;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Hold the item until accepted; valid is left high so a following item
    // can go out on the very next cycle.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] rt, input logic [7:0] code,
                             input logic [15:0] val, input logic [15:0] idx,
                             input logic [15:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {len, idx, val, code, rt};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (kind == KIND_SETUP || kind == KIND_RESET || (kind == KIND_DONE && (xfer_on || pend_valid)))
            served_items++;
        replies_due.push_back(endpoint_reply(kind, {len, idx, val, code, rt}));
    endtask

    // Non-setup item with random payload bits, which the block ignores
    task automatic send_event(input logic [1:0] kind);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(kind, junk[7:0], junk[15:8], junk[31:16], junk[47:32], junk[63:48]);
    endtask

    // Drop valid and hold off until every reply is back and the pipe is empty
    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MAX_PACKET: mps_reg       = data[6:0];
            CFG_HID_IFACE:  hid_iface_reg = data;
            CFG_DEVICE_LEN: dev_len_reg   = data;
            CFG_CONFIG_LEN: cfg_len_reg   = data;
            CFG_HID_OFFSET: hid_off_reg   = data;
            CFG_HID_LEN:    hid_len_reg   = data;
            CFG_REPORT_LEN: rep_len_reg   = data;
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input logic [7:0] mps, input logic [7:0] iface,
                                input logic [7:0] dev_len, input logic [7:0] cfg_len,
                                input logic [7:0] hid_off, input logic [7:0] hid_len,
                                input logic [7:0] rep_len);
        wait_for_replies();
        write_reg(CFG_MAX_PACKET, mps);
        write_reg(CFG_HID_IFACE, iface);
        write_reg(CFG_DEVICE_LEN, dev_len);
        write_reg(CFG_CONFIG_LEN, cfg_len);
        write_reg(CFG_HID_OFFSET, hid_off);
        write_reg(CFG_HID_LEN, hid_len);
        write_reg(CFG_REPORT_LEN, rep_len);
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_packet_size();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'd8;
            3:       return 8'd64;
            4:       return 8'($urandom_range(0, 127));
            5:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8, 64));
        endcase
    endfunction

    // wLength: small, any 16-bit value, the exact descriptor size or just under it, or a packet multiple
    function automatic logic [15:0] pick_length(logic [7:0] full);
        logic [15:0] n;
        case ($urandom_range(4))
            0:       n = 16'($urandom_range(0, 80));
            1:       n = 16'($urandom_range(0, 65535));
            2:       n = {8'd0, full};
            3:       n = 16'(packet_limit() * $urandom_range(0, 4));
            default: n = {8'd0, full} - 16'($urandom_range(0, 2));
        endcase
        return n;
    endfunction

    task automatic shuffle_regs();
        logic [7:0] iface;
        iface = $urandom_range(1) ? 8'($urandom_range(0, 3)) : pick_reg_value();
        set_all_regs(pick_packet_size(), iface, pick_reg_value(), pick_reg_value(),
                     pick_reg_value(), pick_reg_value(), pick_reg_value());
    endtask

    // One request with its follow-up done events, or a stray event
    task automatic random_exchange();
        logic [7:0]  rt;
        logic [7:0]  code;
        logic [15:0] val;
        logic [15:0] idx;
        logic [15:0] len;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            send_event(KIND_RESET);
        end else if (pick < 7) begin
            send_event(KIND_UNUSED);
        end else if (pick < 12) begin
            send_event(KIND_DONE);
        end else begin
            rt   = $urandom_range(1) ? DIR_IN : 8'h00;
            code = REQ_GET_DESCRIPTOR;
            val  = 16'($urandom_range(0, 65535));
            idx  = 16'($urandom_range(0, 65535));
            len  = pick_length(8'hFF);
            case ($urandom_range(11))
                0: code = REQ_GET_STATUS;
                1: begin
                    code = REQ_CLEAR_FEATURE;
                    if ($urandom_range(4) != 0) val = FEAT_REMOTE_WAKEUP;
                end
                2: begin
                    code = REQ_SET_FEATURE;
                    if ($urandom_range(4) != 0) val = FEAT_REMOTE_WAKEUP;
                end
                3: begin
                    code = REQ_SET_ADDRESS;
                    if ($urandom_range(2) != 0) val[15:7] = '0;
                    if ($urandom_range(9) == 0) val = '0;
                end
                4: begin
                    val[15:8] = DT_DEVICE;
                    len = pick_length(dev_len_reg);
                end
                5: begin
                    val[15:8] = DT_CONFIG;
                    if ($urandom_range(4) != 0) val[7:0] = '0;
                    len = pick_length(cfg_len_reg);
                end
                6, 7: begin
                    rt[4:0]   = RCPT_IFACE;
                    val[15:8] = $urandom_range(1) ? DT_HID : DT_REPORT;
                    if ($urandom_range(4) != 0) val[7:0] = '0;
                    if ($urandom_range(5) != 0) idx = {8'd0, hid_iface_reg};
                    len = pick_length((val[15:8] == DT_HID) ? hid_len_reg : rep_len_reg);
                end
                8: begin
                    rt[4:0] = RCPT_ENDPOINT;
                    code    = REQ_GET_STATUS;
                    if ($urandom_range(3) != 0) idx = '0;
                end
                9: begin
                    rt[4:0] = 5'($urandom_range(0, 3));
                    code    = 8'($urandom_range(0, 255));
                end
                default: begin
                    // noise: any type, recipient and direction
                    rt   = 8'($urandom_range(0, 255));
                    code = 8'($urandom_range(0, 7));
                end
            endcase
            send_item(KIND_SETUP, rt, code, val, idx, len);
            // mostly finish the data stage; sometimes abandon it midway
            while (xfer_on && $urandom_range(11) != 0)
                send_event(KIND_DONE);
            if (pend_valid && $urandom_range(6) != 0)
                send_event(KIND_DONE);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests (reset register values unless a test reloads them)
    // ------------------------------------------------------------------
    task automatic test_power_on();
        send_item(KIND_SETUP, DIR_IN, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002);
        send_event(KIND_UNUSED);
    endtask

    task automatic test_remote_wakeup();
        send_item(KIND_SETUP, 8'h00, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 16'h0000, 16'h0000);
        send_item(KIND_SETUP, DIR_IN, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(KIND_SETUP, 8'h00, REQ_CLEAR_FEATURE, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(KIND_SETUP, 8'h00, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 16'h0000, 16'h0000);
    endtask

    // Address above seven bits, then the zero address falling back to default
    task automatic test_set_address();
        send_item(KIND_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFFAB, 16'h0000, 16'h0000);
        send_event(KIND_DONE);
        send_item(KIND_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h0080, 16'h0000, 16'h0000);
        send_event(KIND_DONE);
    endtask

    // Packet size 3 acts as 8; a 16-byte device descriptor ends on a full
    // packet and needs a trailing zero-length packet
    task automatic test_descriptor_chunks();
        set_all_regs(8'h03, 8'h01, 8'd16, 8'hFF, 8'd250, 8'd20, 8'h00);
        send_item(KIND_SETUP, DIR_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'hAB}, 16'h0000, 16'hFFFF);
        send_event(KIND_DONE);
        send_event(KIND_DONE);
        send_item(KIND_SETUP, DIR_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'h0000);
        // a stalled setup still aborts the running transfer
        send_item(KIND_SETUP, DIR_IN, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'hFFFF);
        send_item(KIND_SETUP, RT_VENDOR, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0000, 16'hFFFF);
        send_event(KIND_DONE);
    endtask

    // HID descriptor at offset 250 wraps past 255 on its second chunk
    task automatic test_interface_requests();
        send_item(KIND_SETUP, DIR_IN | 8'(RCPT_IFACE), REQ_GET_DESCRIPTOR, {DT_HID, 8'h00},
                  16'h0001, 16'hFFFF);
        send_event(KIND_DONE);
        send_item(KIND_SETUP, DIR_IN | 8'(RCPT_IFACE), REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00},
                  16'h0101, 16'hFFFF);
        send_item(KIND_SETUP, DIR_IN | 8'(RCPT_IFACE), REQ_GET_DESCRIPTOR, {DT_REPORT, 8'h00},
                  16'h0001, 16'h0005);
    endtask

    task automatic test_endpoint_status();
        send_item(KIND_SETUP, DIR_IN | 8'(RCPT_ENDPOINT), REQ_GET_STATUS, 16'h0000, 16'h0000,
                  16'h0002);
        send_item(KIND_SETUP, DIR_IN | 8'(RCPT_ENDPOINT), REQ_GET_STATUS, 16'h0000, 16'h8000,
                  16'h0002);
    endtask

    // Reset drops wakeup and the pending address; the later done does nothing
    task automatic test_bus_reset();
        send_item(KIND_SETUP, 8'h00, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 16'h0000, 16'h0000);
        send_item(KIND_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h0005, 16'h0000, 16'h0000);
        send_event(KIND_RESET);
        send_event(KIND_DONE);
    endtask

    task automatic test_random_traffic(input int quota, input int sidle, input int ridle);
        int first;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        shuffle_regs();
        first = served_items;
        while (served_items - first < quota) begin
            random_exchange();
            if ($urandom_range(49) == 0)
                wait_for_replies();
            if ($urandom_range(149) == 0)
                shuffle_regs();
        end
        wait_for_replies();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                reply_head = replies_due.pop_front();
                check_field("stall_res", 32'(reply_head.stall), 32'(m_axis_tuser[0]));
                check_field("send_packet", 32'(reply_head.send), 32'(m_axis_tuser[1]));
                check_field("packet_source", 32'(reply_head.src), 32'(m_axis_tdata[2:0]));
                check_field("packet_offset", 32'(reply_head.offset), 32'(m_axis_tdata[10:3]));
                check_field("packet_count", 32'(reply_head.count), 32'(m_axis_tdata[17:11]));
                check_field("status_low_byte", 32'(reply_head.status),
                            32'(m_axis_tdata[25:18]));
                check_field("device_address", 32'(reply_head.addr), 32'(m_axis_tdata[32:26]));
                check_field("device_state", 32'(reply_head.dstate), 32'(m_axis_tdata[34:33]));
                check_field("wakeup_enabled", 32'(reply_head.wake), 32'(m_axis_tdata[35]));
                check_field("tdata padding", 32'd0, 32'(m_axis_tdata[39:36]));
            end
        end
    end

    // Count cycles in which no item moves on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        clear_endpoint_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 66;
        test_power_on();
        test_remote_wakeup();
        test_set_address();
        test_descriptor_chunks();
        test_interface_requests();
        test_endpoint_status();
        test_bus_reset();
        test_random_traffic(600, 14, 66);
        test_random_traffic(600, 66, 14);
        test_random_traffic(600, 0, 0);
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
